### hw/rtl/bfd_pkg.sv
// shared types and constants for the byte frame deframer
// no dependencies
`timescale 1ns / 1ps

package bfd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int BUF_DEPTH   = MAX_PAYLOAD + 1;
    localparam int COUNT_SAT   = MAX_PAYLOAD + 2;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = $clog2(COUNT_SAT + 1);
    localparam int IDX_W  = $clog2(BUF_DEPTH);
    // two banks of frame storage, bank select on top of the index
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd2;

    localparam logic [BYTE_W-1:0] RST_START_BYTE   = 8'h55;
    localparam logic [BYTE_W-1:0] RST_END_BYTE     = 8'hdd;
    localparam logic [LEN_W-1:0]  RST_FRAME_LENGTH = 6'd17;

    typedef enum logic {
        FS_GATHER,
        FS_CHECK
    } t_front_state;

    // one accepted frame waiting to be drained
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] len;
    } t_desc;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

endpackage

### hw/rtl/bfd_in_if.sv
// input byte channel of the deframer
// depends on bfd_pkg
`timescale 1ns / 1ps

interface bfd_in_if
    import bfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/bfd_out_if.sv
// payload output channel of the deframer
// depends on bfd_pkg
`timescale 1ns / 1ps

interface bfd_out_if
    import bfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;

    modport source (output valid, output payload_byte, output last, input ready);
    modport sink   (input valid, input payload_byte, input last, output ready);
endinterface

### hw/rtl/bfd_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hw/rtl/bfd_front.sv
// front end: config registers, byte classification, gathering and frame check
// depends on bfd_pkg and bfd_in_if
`timescale 1ns / 1ps

module bfd_front
    import bfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    bfd_in_if.sink               i_rx,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_desc                o_q_desc,
    output t_ram_wr              o_ram_wr,
    output t_ram_rd              o_ram_rd,
    input  logic [BYTE_W-1:0]    i_ram_rdata
);

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_end_byte;
    logic [LEN_W-1:0]  r_frame_length;

    t_front_state      r_state, n_state;
    logic              r_bank, n_bank;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [LEN_W-1:0]  r_chk_len, n_chk_len;

    logic accept;
    logic is_start;
    logic is_end;
    logic len_ok;
    logic cnt_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte   <= RST_START_BYTE;
            r_end_byte     <= RST_END_BYTE;
            r_frame_length <= RST_FRAME_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_BYTE:   r_start_byte   <= i_cfg_data;
                CFG_END_BYTE:     r_end_byte     <= i_cfg_data;
                CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_GATHER;
            r_bank  <= 1'b0;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_len <= n_chk_len;
    end

    // the write bank is free whenever the queue has room
    assign i_rx.ready = (r_state == FS_GATHER) && !i_q_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign is_start   = (i_rx.rx_byte == r_start_byte);
    assign is_end     = !is_start && (i_rx.rx_byte == r_end_byte);
    assign len_ok     = (r_frame_length != '0) &&
                        ({1'b0, r_frame_length} <= (LEN_W+1)'(MAX_PAYLOAD));
    assign cnt_ok     = ({1'b0, r_cnt} == ({1'b0, r_frame_length} + (LEN_W+1)'(1)));

    always_comb begin
        n_state   = r_state;
        n_bank    = r_bank;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_chk_len = r_chk_len;
        o_q_push  = 1'b0;
        o_q_desc  = '{bank: r_bank, len: r_chk_len};
        o_ram_wr  = '{en: 1'b0, addr: {r_bank, r_cnt[IDX_W-1:0]}, data: i_rx.rx_byte};
        o_ram_rd  = '{en: 1'b0, addr: {r_bank, r_frame_length[IDX_W-1:0]}};

        unique case (r_state)
            FS_GATHER: begin
                if (accept) begin
                    if (is_start) begin
                        n_cnt = '0;
                        n_sum = '0;
                    end else if (is_end) begin
                        // fetch the checksum byte, compare next cycle
                        if (len_ok && cnt_ok) begin
                            o_ram_rd.en = 1'b1;
                            n_chk_len   = r_frame_length;
                            n_state     = FS_CHECK;
                        end
                    end else begin
                        o_ram_wr.en = (r_cnt < CNT_W'(BUF_DEPTH));
                        if (r_cnt < CNT_W'(COUNT_SAT)) begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                        n_sum = r_sum + i_rx.rx_byte;
                    end
                end
            end
            FS_CHECK: begin
                n_state = FS_GATHER;
                if ((r_sum - i_ram_rdata) == i_ram_rdata) begin
                    o_q_push = 1'b1;
                    n_bank   = !r_bank;
                    n_cnt    = '0;
                    n_sum    = '0;
                end
            end
            default: n_state = FS_GATHER;
        endcase
    end

endmodule

### hw/rtl/bfd_fq.sv
// two-entry queue of accepted frame descriptors between front and back
// depends on bfd_pkg
`timescale 1ns / 1ps

module bfd_fq
    import bfd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_head,
    output logic  o_full,
    output logic  o_empty
);

    t_desc      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_desc;
        end
    end

    assign o_head  = r_q[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

### hw/rtl/bfd_back.sv
// back end: drains queued frames from the buffer ram, one beat per cycle while the output is ready
// depends on bfd_pkg and bfd_out_if
`timescale 1ns / 1ps

module bfd_back
    import bfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_desc             i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output t_ram_rd           o_ram_rd,
    input  logic [BYTE_W-1:0] i_ram_rdata,
    bfd_out_if.source         o_frm
);

    logic [IDX_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic load_out;
    logic issue;
    logic is_last;

    // ram data register acts as the skid stage ahead of the output register
    assign load_out = r_rd_vld && (!r_out_vld || o_frm.ready);
    assign issue    = !i_empty && (!r_rd_vld || load_out);
    assign is_last  = ({1'b0, r_idx} == ({1'b0, i_head.len} - (LEN_W+1)'(1)));

    assign o_pop    = issue && is_last;
    assign o_ram_rd = '{en: issue, addr: {i_head.bank, r_idx}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (issue) begin
                r_idx <= is_last ? '0 : r_idx + IDX_W'(1);
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (load_out) begin
                r_rd_vld <= 1'b0;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_frm.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_last <= is_last;
        end
        if (load_out) begin
            r_out_byte <= i_ram_rdata;
            r_out_last <= r_rd_last;
        end
    end

    assign o_frm.valid        = r_out_vld;
    assign o_frm.payload_byte = r_out_byte;
    assign o_frm.last         = r_out_last;

endmodule

### hw/rtl/byte_frame_deframer_checksum.sv
// start/end byte deframer with additive checksum, one rx byte per beat
// output: checksum check, queue push, ram read, output reg; one beat per cycle while ready
// throughput: one rx byte per cycle while ready; an end byte that passes the length check
//   holds the input in the check state for the checksum read from the buffer ram
// input stalls while a second frame is complete and the first still drains
// reset: synchronous active low; clears control and config, the buffer ram is not cleared
`timescale 1ns / 1ps

module byte_frame_deframer_checksum
    import bfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    bfd_in_if.sink               i_rx,
    bfd_out_if.source            o_frm
);

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    t_desc             q_desc;
    t_desc             q_head;
    t_ram_wr           ram_wr;
    t_ram_rd           ram_rd_front;
    t_ram_rd           ram_rd_back;
    logic [BYTE_W-1:0] rdata_front;
    logic [BYTE_W-1:0] rdata_back;

    bfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_rx        (i_rx),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_desc    (q_desc),
        .o_ram_wr    (ram_wr),
        .o_ram_rd    (ram_rd_front),
        .i_ram_rdata (rdata_front)
    );

    bfd_fq u_fq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_desc),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_wr.en),
        .i_waddr   (ram_wr.addr),
        .i_wdata   (ram_wr.data),
        .i_re_a    (ram_rd_front.en),
        .i_raddr_a (ram_rd_front.addr),
        .o_rdata_a (rdata_front),
        .i_re_b    (ram_rd_back.en),
        .i_raddr_b (ram_rd_back.addr),
        .o_rdata_b (rdata_back)
    );

    bfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_ram_rd    (ram_rd_back),
        .i_ram_rdata (rdata_back),
        .o_frm       (o_frm)
    );

endmodule
